/* rtl/tiex_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tiex_pkg
// Opcodes, compare codes and stream widths of the toy ISA execute unit.
// ----------------------------------------------------------------------------
package tiex_pkg;

   localparam int unsigned PC_W    = 12;
   localparam int unsigned OPND_W  = 11;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned TGT_W   = 13;

   // Program memory size; the next pc wraps at this depth.
   localparam int unsigned PROGRAM_DEPTH = 4096;

   // Request tdata: pc, opcode, dest, src1, src2, compare, target, data
   localparam int unsigned REQ_DATA_W = 104;
   // Response tdata: next_pc, print_value
   localparam int unsigned RSP_DATA_W = 48;

   localparam logic [3:0] OP_MOV   = 4'd1;
   localparam logic [3:0] OP_ADD   = 4'd2;
   localparam logic [3:0] OP_SUB   = 4'd3;
   localparam logic [3:0] OP_MUL   = 4'd4;
   localparam logic [3:0] OP_JMP   = 4'd5;
   localparam logic [3:0] OP_IF    = 4'd6;
   localparam logic [3:0] OP_PRINT = 4'd12;
   localparam logic [3:0] OP_READ  = 4'd13;

   localparam logic [3:0] CMP_EQ = 4'd7;
   localparam logic [3:0] CMP_LT = 4'd8;
   localparam logic [3:0] CMP_GT = 4'd9;
   localparam logic [3:0] CMP_LE = 4'd10;
   localparam logic [3:0] CMP_GE = 4'd11;

   // Item kind carried on req_tuser
   localparam logic KIND_INIT = 1'b0;
   localparam logic KIND_EXEC = 1'b1;

endpackage : tiex_pkg
`default_nettype wire

/* rtl/toy_isa_execute_unit_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// A req transfer passes stage 1 and the output register. Throughput: one
//   instruction per cycle unless rsp stalls; the data memory has two read
//   ports and one write port, and the previous instruction's result is forwarded
//   into the operand registers, so back-to-back dependent items do not stall.
// Reset: clears the stage and output valid flags only. The data memory is not
//   cleared; a word reads as garbage until it has been written.
// ----------------------------------------------------------------------------
// toy_isa_execute_unit_top
// Executes one instruction (or one initial memory write) per transfer over a
// MEM_WORDS x 32 data memory and returns the next pc and any printed word.
// ----------------------------------------------------------------------------
module toy_isa_execute_unit_top #(
   parameter int unsigned MEM_WORDS = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata, lowest bit up: pc[11:0], opcode[15:12], dest_operand[26:16],
   //   src1_operand[37:27], src2_operand[48:38], compare_code[52:49],
   //   jump_target[65:53], data_value[97:66], zero fill[103:98]
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [tiex_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: kind[0]
   input  wire logic                             req_tuser,
   // rsp_tdata, lowest bit up: next_pc[11:0], print_value[43:12],
   //   zero fill[47:44]
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [tiex_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: print_valid[0]
   output      logic                             rsp_tuser
);
   import tiex_pkg::*;

   localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   // Operands span -1024..+1023; an offset of whole memory sizes keeps the mapped
   // address positive before the modulo reduction.
   localparam int unsigned OPERAND_SPAN = 1024;
   localparam int unsigned MAP_OFS =
      MEM_WORDS * ((OPERAND_SPAN + MEM_WORDS - 1) / MEM_WORDS);
   localparam int unsigned RED_SH = 18;
   localparam int unsigned RECIP  = (1 << RED_SH) / MEM_WORDS;

   // Map an operand to a memory address: negative v goes to MEM_WORDS-1+v,
   // then reduce modulo MEM_WORDS by reciprocal multiply and one correction.
   function automatic logic [AW-1:0] map_addr(input logic [OPND_W-1:0] v);
      logic [19:0] ext;
      logic [19:0] m;
      logic [17:0] x;
      logic [35:0] prod;
      logic [17:0] q;
      logic [35:0] qw;
      logic [17:0] r;
      ext  = {{(20-OPND_W){v[OPND_W-1]}}, v};
      m    = v[OPND_W-1] ? (20'(MEM_WORDS - 1) + ext) : ext;
      x    = m[17:0] + 18'(MAP_OFS);
      prod = 36'(x) * 36'(RECIP);
      q    = prod[35:RED_SH];
      qw   = 36'(q) * 36'(MEM_WORDS);
      r    = x - qw[17:0];
      if (r >= 18'(MEM_WORDS)) begin
         r = r - 18'(MEM_WORDS);
      end
      return r[AW-1:0];
   endfunction

   // Unpack the request
   logic [PC_W-1:0]    f_pc;
   logic [3:0]         f_opcode;
   logic [OPND_W-1:0]  f_dest;
   logic [OPND_W-1:0]  f_src1;
   logic [OPND_W-1:0]  f_src2;
   logic [3:0]         f_cmp;
   logic [TGT_W-1:0]   f_target;
   logic [WORD_W-1:0]  f_data;

   assign f_pc     = req_tdata[11:0];
   assign f_opcode = req_tdata[15:12];
   assign f_dest   = req_tdata[26:16];
   assign f_src1   = req_tdata[37:27];
   assign f_src2   = req_tdata[48:38];
   assign f_cmp    = req_tdata[52:49];
   assign f_target = req_tdata[65:53];
   assign f_data   = req_tdata[97:66];

   logic [AW-1:0] ad_in, a1_in, a2_in;
   assign ad_in = map_addr(f_dest);
   assign a1_in = map_addr(f_src1);
   assign a2_in = map_addr(f_src2);

   // Read port A serves src1, or dest for PRINT; port B serves src2, or dest
   // for IF (the left side of the compare).
   logic [AW-1:0] rd_addr_a_in, rd_addr_b_in;
   assign rd_addr_a_in = (f_opcode == OP_PRINT) ? ad_in : a1_in;
   assign rd_addr_b_in = (f_opcode == OP_IF)    ? ad_in : a2_in;

   // ------------------------------------------------------------------------
   // Handshake: stage 1 holds the instruction and its operands, the output
   // register the result. Stage 1 drains whenever the output register is empty
   // or being taken, so a new transfer enters every cycle unless rsp stalls.
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_open;
   logic s1_advance;
   logic req_accept;

   assign out_open   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_open;
   assign req_tready = !s1_valid_ff || out_open;
   assign req_accept = req_tvalid && req_tready;

   // Stage 1 payload
   logic              s1_kind_ff;
   logic [PC_W-1:0]   s1_pc_ff;
   logic [3:0]        s1_opcode_ff;
   logic [AW-1:0]     s1_ad_ff;
   logic [3:0]        s1_cmp_ff;
   logic [PC_W-1:0]   s1_target_ff;
   logic [WORD_W-1:0] s1_data_ff;

   // Operand registers and forwarding
   logic [WORD_W-1:0] rd_a_ff, rd_b_ff;
   logic              byp_a_ff, byp_b_ff;
   logic              byp_a_in, byp_b_in;
   logic [WORD_W-1:0] byp_data_ff;

   logic [WORD_W-1:0] mem [MEM_WORDS];

   // ------------------------------------------------------------------------
   // Execute (stage 1)
   // ------------------------------------------------------------------------
   logic [WORD_W-1:0] opnd_a, opnd_b;
   logic [WORD_W-1:0] wr_data;
   logic              wr_op;
   logic              wr_en;
   logic              cmp_known, cmp_pass;
   logic [PC_W-1:0]   next_pc_in;
   logic              print_valid_in;
   logic [WORD_W-1:0] print_value_in;
   logic [PC_W-1:0]   pc_inc, pc_jump;

   assign opnd_a  = byp_a_ff ? byp_data_ff : rd_a_ff;
   assign opnd_b  = byp_b_ff ? byp_data_ff : rd_b_ff;
   assign pc_inc  = s1_pc_ff + 1'b1;       // wraps at PROGRAM_DEPTH
   assign pc_jump = s1_target_ff - 1'b1;   // 1-based target, wraps to top

   always_comb begin
      wr_data   = s1_data_ff;
      wr_op     = 1'b0;
      cmp_known = 1'b1;
      cmp_pass  = 1'b1;
      next_pc_in     = pc_inc;
      print_valid_in = 1'b0;
      print_value_in = '0;
      if (s1_kind_ff == KIND_INIT) begin
         wr_op      = 1'b1;
         next_pc_in = s1_pc_ff;
      end else begin
         unique case (s1_opcode_ff)
            OP_MOV: begin
               wr_op   = 1'b1;
               wr_data = opnd_a;
            end
            OP_ADD: begin
               wr_op   = 1'b1;
               wr_data = opnd_a + opnd_b;
            end
            OP_SUB: begin
               wr_op   = 1'b1;
               wr_data = opnd_a - opnd_b;
            end
            OP_MUL: begin
               wr_op   = 1'b1;
               wr_data = opnd_a * opnd_b;
            end
            OP_JMP: begin
               next_pc_in = pc_jump;
            end
            OP_IF: begin
               // left side is the dest word on port B, right side src1 on A
               unique case (s1_cmp_ff)
                  CMP_EQ:  cmp_pass = (opnd_b == opnd_a);
                  CMP_LT:  cmp_pass = ($signed(opnd_b) <  $signed(opnd_a));
                  CMP_GT:  cmp_pass = ($signed(opnd_b) >  $signed(opnd_a));
                  CMP_LE:  cmp_pass = ($signed(opnd_b) <= $signed(opnd_a));
                  CMP_GE:  cmp_pass = ($signed(opnd_b) >= $signed(opnd_a));
                  default: cmp_known = 1'b0;
               endcase
               if (cmp_known && !cmp_pass) begin
                  next_pc_in = pc_jump;
               end
            end
            OP_PRINT: begin
               print_valid_in = 1'b1;
               print_value_in = opnd_a;
            end
            OP_READ: begin
               wr_op = 1'b1;
            end
            default: begin
               // unknown opcode: just step the pc
            end
         endcase
      end
   end

   // Commit the write exactly once, as the instruction leaves stage 1
   assign wr_en = s1_advance && wr_op;

   // Forward the committing write into the operands of the entering item
   assign byp_a_in = wr_en && (rd_addr_a_in == s1_ad_ff);
   assign byp_b_in = wr_en && (rd_addr_b_in == s1_ad_ff);

   // ------------------------------------------------------------------------
   // Data memory: one write port, two registered read ports
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_ad_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_a_ff <= mem[rd_addr_a_in];
         rd_b_ff <= mem[rd_addr_b_in];
      end
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
      rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage 1 payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff   <= req_tuser;
         s1_pc_ff     <= f_pc;
         s1_opcode_ff <= f_opcode;
         s1_ad_ff     <= ad_in;
         s1_cmp_ff    <= f_cmp;
         s1_target_ff <= f_target[PC_W-1:0];
         s1_data_ff   <= f_data;
         byp_a_ff     <= byp_a_in;
         byp_b_ff     <= byp_b_in;
         byp_data_ff  <= wr_data;
      end
   end

   // Output register
   logic [PC_W-1:0]   rsp_next_pc_ff;
   logic              rsp_print_valid_ff;
   logic [WORD_W-1:0] rsp_print_value_ff;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_next_pc_ff     <= next_pc_in;
         rsp_print_valid_ff <= print_valid_in;
         rsp_print_value_ff <= print_value_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_print_value_ff, rsp_next_pc_ff};
   assign rsp_tuser  = rsp_print_valid_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_adv_fills_out : assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("stage 1 drained but no result was registered");

   a_ready_only_blocked : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request stalled while the pipeline could move");

   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=>
         (s1_valid_ff && $stable(s1_pc_ff) && $stable(s1_ad_ff) && $stable(rd_a_ff)))
      else $error("stalled instruction or its operands changed");

   a_print_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_print_valid_ff) |-> (rsp_print_value_ff == '0))
      else $error("print value nonzero on a non-print result");

endmodule : toy_isa_execute_unit_top
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the toy ISA execute unit. Drives init writes and
// instructions on req, mirrors the data memory in a local predictor and
// compares every rsp transfer, field by field, with the oldest prediction.
// Reads are only ever aimed at words that were written before.
// ----------------------------------------------------------------------------
module tb_top;
   import tiex_pkg::*;

   localparam int unsigned DEPTH_WORDS    = 1024;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 16;
   localparam int unsigned RANDOM_ITEMS   = 1500;
   localparam int unsigned BURST_ITEMS    = 320;
   localparam int unsigned MAX_REPORTS    = 10;

   // Codes outside the decoded sets, used to hit the fall-through paths
   localparam logic [3:0] OP_UNUSED_LO  = 4'd0;
   localparam logic [3:0] OP_UNUSED_HI  = 4'd15;
   localparam logic [3:0] CMP_UNUSED_LO = 4'd0;
   localparam logic [3:0] CMP_UNUSED_HI = 4'd15;

   typedef struct {
      logic               kind;
      logic [11:0]        pc;
      logic [3:0]         opcode;
      logic signed [10:0] dest;
      logic signed [10:0] src1;
      logic signed [10:0] src2;
      logic [3:0]         cmp;
      logic [12:0]        target;
      logic [31:0]        value;
   } instr_item_type;

   typedef struct {
      logic [11:0] next_pc;
      logic        print_valid;
      logic [31:0] print_value;
   } exec_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // Predictor state: mirror of the data memory and which words hold data
   logic [31:0]  mem_mirror  [0:DEPTH_WORDS-1];
   bit           mem_written [0:DEPTH_WORDS-1];
   int           written_addrs[$];
   int           last_written;

   exec_result_type expected_results[$];
   int              mismatch_count = 0;
   bit              req_no_idle    = 1'b0;
   bit              rsp_no_stall   = 1'b0;

   toy_isa_execute_unit_top #(
      .MEM_WORDS (DEPTH_WORDS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Negative operands address the register file at the top of memory;
   // anything past either end wraps around the memory size.
   function automatic int map_operand(logic signed [10:0] opnd);
      int a;
      a = (opnd < 0) ? (DEPTH_WORDS - 1) + int'(opnd) : int'(opnd);
      a = a % DEPTH_WORDS;
      if (a < 0) a += DEPTH_WORDS;
      return a;
   endfunction

   function automatic void store_word(int a, logic [31:0] w);
      mem_mirror[a] = w;
      if (!mem_written[a]) begin
         mem_written[a] = 1'b1;
         written_addrs.push_back(a);
      end
      last_written = a;
   endfunction

   // Targets are 1-based; drop to 0-based and wrap at the program depth.
   function automatic logic [11:0] target_to_pc(logic [12:0] target);
      logic [12:0] t;
      t = target - 13'd1;
      return t[11:0];
   endfunction

   function automatic exec_result_type predict_execute(instr_item_type it);
      exec_result_type    r;
      int                 ad, a1, a2;
      logic [31:0]        x, y;
      logic signed [31:0] lhs, rhs;
      bit                 known, pass;
      ad = map_operand(it.dest);
      a1 = map_operand(it.src1);
      a2 = map_operand(it.src2);
      r.next_pc     = it.pc + 12'd1;
      r.print_valid = 1'b0;
      r.print_value = '0;
      if (it.kind == KIND_INIT) begin
         store_word(ad, it.value);
         r.next_pc = it.pc;
      end else begin
         x = mem_mirror[a1];
         y = mem_mirror[a2];
         case (it.opcode)
            OP_MOV:   store_word(ad, x);
            OP_ADD:   store_word(ad, x + y);
            OP_SUB:   store_word(ad, x - y);
            OP_MUL:   store_word(ad, x * y);
            OP_JMP:   r.next_pc = target_to_pc(it.target);
            OP_IF: begin
               lhs   = mem_mirror[ad];
               rhs   = x;
               known = 1'b1;
               pass  = 1'b0;
               case (it.cmp)
                  CMP_EQ:  pass = (lhs == rhs);
                  CMP_LT:  pass = (lhs <  rhs);
                  CMP_GT:  pass = (lhs >  rhs);
                  CMP_LE:  pass = (lhs <= rhs);
                  CMP_GE:  pass = (lhs >= rhs);
                  default: known = 1'b0;
               endcase
               // Failed test branches; unknown compare just falls through
               if (known && !pass) r.next_pc = target_to_pc(it.target);
            end
            OP_PRINT: begin
               r.print_valid = 1'b1;
               r.print_value = mem_mirror[ad];
            end
            OP_READ:  store_word(ad, it.value);
            default: ;
         endcase
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Pick one of the operand encodings that land on word a.
   function automatic logic signed [10:0] encode_addr(int a);
      if ($urandom_range(0, 1) == 0) return 11'(a);
      if (a == DEPTH_WORDS - 1) return 11'(-1024);
      return 11'(a - (DEPTH_WORDS - 1));
   endfunction

   // Source words come from the written set, or word 0 while it is empty; chained mode leans on
   // the word written last to hammer the forwarding path.
   function automatic int pick_read_addr(bit chained);
      int prob;
      prob = chained ? 80 : 35;
      if (written_addrs.size() == 0) return 0;
      if ($urandom_range(0, 99) < prob) return last_written;
      return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
   endfunction

   function automatic int pick_write_addr();
      if (written_addrs.size() != 0 && $urandom_range(0, 1) == 0)
         return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
      return $urandom_range(0, DEPTH_WORDS - 1);
   endfunction

   function automatic instr_item_type make_item(logic kind, logic [11:0] pc,
                                                logic [3:0] opcode,
                                                int dest,
                                                int src1,
                                                int src2,
                                                logic [3:0] cmp,
                                                logic [12:0] target,
                                                logic [31:0] value);
      instr_item_type it;
      it.kind   = kind;
      it.pc     = pc;
      it.opcode = opcode;
      it.dest   = 11'(dest);
      it.src1   = 11'(src1);
      it.src2   = 11'(src2);
      it.cmp    = cmp;
      it.target = target;
      it.value  = value;
      return it;
   endfunction

   function automatic instr_item_type gen_random_item(bit chained);
      instr_item_type it;
      int             r;
      bit             writes;
      it.kind = ($urandom_range(0, 9) == 0) ? KIND_INIT : KIND_EXEC;
      r = $urandom_range(0, 99);
      if      (r < 15) it.opcode = OP_MOV;
      else if (r < 30) it.opcode = OP_ADD;
      else if (r < 42) it.opcode = OP_SUB;
      else if (r < 54) it.opcode = OP_MUL;
      else if (r < 60) it.opcode = OP_JMP;
      else if (r < 75) it.opcode = OP_IF;
      else if (r < 85) it.opcode = OP_PRINT;
      else if (r < 93) it.opcode = OP_READ;
      else             it.opcode = 4'($urandom_range(0, 15));
      it.pc     = 12'($urandom_range(0, 4095));
      it.target = 13'($urandom_range(0, 8191));
      if (it.opcode == OP_IF && $urandom_range(0, 99) < 85)
         it.cmp = 4'($urandom_range(CMP_EQ, CMP_GE));
      else
         it.cmp = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 19))
         0:       it.value = 32'h0000_0000;
         1:       it.value = 32'h0000_0001;
         2:       it.value = 32'hFFFF_FFFF;
         3:       it.value = 32'h7FFF_FFFF;
         4:       it.value = 32'h8000_0000;
         default: it.value = $urandom;
      endcase
      writes = (it.kind == KIND_INIT);
      if (it.kind == KIND_EXEC) begin
         case (it.opcode)
            OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_READ: writes = 1'b1;
            default: ;
         endcase
      end
      it.dest = writes ? encode_addr(pick_write_addr()) :
                         encode_addr(pick_read_addr(chained));
      it.src1 = encode_addr(pick_read_addr(chained));
      it.src2 = encode_addr(pick_read_addr(chained));
      return it;
   endfunction

   // Present one item, hold it until the transfer, then log its prediction.
   // A valid that stays up for the next item is never dropped in between.
   task automatic send_item(input instr_item_type it);
      int gap;
      gap = pick_gap(req_no_idle);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {6'd0, it.value, it.target, it.cmp, it.src2, it.src1,
                     it.dest, it.opcode, it.pc};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_execute(it));
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Seed memory with the word extremes through positive and negative encodings.
   task automatic test_init_extremes();
      send_item(make_item(KIND_INIT, 12'd0, OP_UNUSED_LO, 1, 1, 1,
                          CMP_UNUSED_LO, 13'd1, 32'h0000_0001));
      send_item(make_item(KIND_INIT, 12'd4095, OP_UNUSED_HI, -1023, 1, 1,
                          CMP_UNUSED_HI, 13'd8191, 32'h7FFF_FFFF));
      send_item(make_item(KIND_INIT, 12'd1, OP_MOV, 1023, 0, 0,
                          CMP_EQ, 13'd2, 32'h8000_0000));
      send_item(make_item(KIND_INIT, 12'd2, OP_ADD, -1, 0, 0,
                          CMP_LT, 13'd3, 32'hFFFF_FFFF));
      send_item(make_item(KIND_INIT, 12'd3, OP_SUB, 2, 0, 0,
                          CMP_GT, 13'd4, 32'h0000_0000));
   endtask

   // Overflow on each arithmetic op, then a move and a print that depends on it.
   task automatic test_arith_wrap();
      send_item(make_item(KIND_EXEC, 12'd10, OP_ADD, 3, -1023, 1,
                          CMP_EQ, 13'd1, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd11, OP_SUB, 4, 1023, 1,
                          CMP_EQ, 13'd1, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd12, OP_MUL, 5, -1, -1,
                          CMP_EQ, 13'd1, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd13, OP_MUL, 7, 0, 0,
                          CMP_EQ, 13'd1, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd14, OP_MOV, -1024, 1, 1,
                          CMP_EQ, 13'd1, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd15, OP_PRINT, 1023, 1, 1,
                          CMP_EQ, 13'd1, 32'd0));
   endtask

   // Read straight into a print, and a print at the last pc so it wraps.
   task automatic test_read_print();
      send_item(make_item(KIND_EXEC, 12'd20, OP_READ, 6, 0, 0,
                          CMP_EQ, 13'd1, 32'h8000_0000));
      send_item(make_item(KIND_EXEC, 12'd21, OP_PRINT, 6, 0, 0,
                          CMP_EQ, 13'd1, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd4095, OP_PRINT, -1, 0, 0,
                          CMP_EQ, 13'd1, 32'd0));
   endtask

   // Zero target wraps to the last pc; targets past the depth wrap too.
   task automatic test_jumps();
      send_item(make_item(KIND_EXEC, 12'd30, OP_JMP, 0, 0, 0,
                          CMP_EQ, 13'd0, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd31, OP_JMP, 0, 0, 0,
                          CMP_EQ, 13'd1, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd32, OP_JMP, 0, 0, 0,
                          CMP_EQ, 13'd4097, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd33, OP_JMP, 0, 0, 0,
                          CMP_EQ, 13'd8191, 32'd0));
   endtask

   // Every compare code against max and min words, plus one unknown code.
   task automatic test_compare_codes();
      send_item(make_item(KIND_EXEC, 12'd40, OP_IF, 3, 3, 0,
                          CMP_EQ, 13'd100, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd41, OP_IF, 0, 3, 0,
                          CMP_LT, 13'd101, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd42, OP_IF, 0, 3, 0,
                          CMP_GT, 13'd102, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd43, OP_IF, 0, 3, 0,
                          CMP_LE, 13'd103, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd44, OP_IF, 0, 3, 0,
                          CMP_GE, 13'd104, 32'd0));
      send_item(make_item(KIND_EXEC, 12'd45, OP_IF, 0, 3, 0,
                          CMP_UNUSED_HI, 13'd105, 32'd0));
   endtask

   // Undecoded opcodes only advance the pc.
   task automatic test_unknown_opcodes();
      send_item(make_item(KIND_EXEC, 12'd50, OP_UNUSED_LO, 1, 1, 1,
                          CMP_EQ, 13'd200, 32'hDEAD_BEEF));
      send_item(make_item(KIND_EXEC, 12'd51, OP_UNUSED_HI, 2, 2, 2,
                          CMP_GE, 13'd201, 32'h1234_5678));
   endtask

   // Random programs with idle on both sides, quiet stretches now and then.
   task automatic test_random_program(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) req_no_idle = ($urandom_range(0, 3) == 0);
         send_item(gen_random_item(1'b0));
      end
   endtask

   // Back-to-back dependent chains to stress read-after-write forwarding.
   task automatic test_dependent_bursts(int n);
      req_no_idle = 1'b1;
      for (int i = 0; i < n; i++) send_item(gen_random_item(1'b1));
      req_no_idle = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Result side: random backpressure and field-by-field compare
   // -------------------------------------------------------------------------
   int stall_left = 0;
   int rsp_cycle  = 0;

   always @(posedge clock) begin
      exec_result_type exp_r;
      int              g;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("[%0t] unexpected rsp transfer: next_pc=%0d pv=%b val=%h",
                           $realtime, rsp_tdata[11:0], rsp_tuser, rsp_tdata[43:12]);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_tdata[11:0] !== exp_r.next_pc ||
                   rsp_tuser !== exp_r.print_valid ||
                   rsp_tdata[43:12] !== exp_r.print_value) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"[%0t] rsp mismatch: next_pc exp %0d got %0d, ",
                               "pv exp %b got %b, val exp %h got %h"},
                              $realtime, exp_r.next_pc, rsp_tdata[11:0],
                              exp_r.print_valid, rsp_tuser,
                              exp_r.print_value, rsp_tdata[43:12]);
               end
            end
         end
         // Reroll the no-stall stretch every so often
         rsp_cycle++;
         if (rsp_cycle % 128 == 0) rsp_no_stall = ($urandom_range(0, 3) == 0);
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            g = pick_gap(rsp_no_stall);
            if (g == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               stall_left = g - 1;
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   // Watchdog: abort if neither side moves a transfer for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      // Hold reset, then release it once
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_init_extremes();
      test_arith_wrap();
      test_read_print();
      test_jumps();
      test_compare_codes();
      test_unknown_opcodes();
      test_random_program(RANDOM_ITEMS);
      test_dependent_bursts(BURST_ITEMS);

      // Drop valid in the step of the last transfer, then drain
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule : tb_top

/* sim.f */
rtl/tiex_pkg.sv
rtl/toy_isa_execute_unit_top.sv
bench/tb_top.sv
